// ===== rtl/vsom_pkg.sv =====
package vsom_pkg;

   localparam int OFFSET_BITS    = 48;
   localparam int SERVER_BITS    = 8;
   localparam int DEF_MAX_STRIPS = 16;
   localparam int DW             = 64;
   localparam int STEP_BITS      = $clog2(DW + 1);

   localparam logic [DW-1:0] OFF_MAX = (DW'(1) << OFFSET_BITS) - DW'(1);

   localparam logic [2:0] CMD_LOAD = 3'd0;
   localparam logic [2:0] CMD_L2P  = 3'd1;
   localparam logic [2:0] CMD_P2L  = 3'd2;
   localparam logic [2:0] CMD_NEXT = 3'd3;
   localparam logic [2:0] CMD_LEN  = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_OWNED = 2'd1;
   localparam logic [1:0] ST_NO_STRIP  = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   localparam logic REG_COUNT  = 1'b0;
   localparam logic REG_SERVER = 1'b1;

   typedef struct packed {
      logic [2:0]  command;
      logic [3:0]  entry_index;
      logic [47:0] entry_start;
      logic [47:0] entry_length;
      logic [7:0]  entry_owner;
      logic [47:0] offset_in;
   } req_type;

   typedef struct packed {
      logic [47:0] result_value;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] start;
      logic [OFFSET_BITS-1:0] length;
      logic [SERVER_BITS-1:0] owner;
   } entry_type;

   typedef enum logic {
      ALU_DIV,
      ALU_MUL
   } alu_op_type;

   typedef struct packed {
      logic          start;
      alu_op_type    op;
      logic [DW-1:0] a;
      logic [DW-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic          done;
      logic [DW-1:0] quo;
      logic [DW-1:0] rem;
   } alu_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SIZE,
      S_TOTAL,
      S_DIV_A,
      S_L2P,
      S_L2P_MUL,
      S_ADD,
      S_DIV_P,
      S_P2L,
      S_P2L_MUL,
      S_C4_START,
      S_C4_DIV,
      S_C4_WALK,
      S_C3A,
      S_C3B,
      S_C3_MUL,
      S_C3C,
      S_DONE
   } state_type;

   function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
      logic [DW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DW] ? '1 : s[DW-1:0];
   endfunction

endpackage

// ===== rtl/vsom_table.sv =====
module vsom_table #(
   parameter int MAX_STRIPS = vsom_pkg::DEF_MAX_STRIPS,
   parameter int IW         = 4
) (
   input  logic                clock,
   input  logic                we,
   input  logic [IW-1:0]       waddr,
   input  vsom_pkg::entry_type wdata,
   input  logic [IW-1:0]       raddr,
   output vsom_pkg::entry_type rdata
);
   import vsom_pkg::*;

   entry_type mem [MAX_STRIPS];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/vsom_alu.sv =====
module vsom_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  vsom_pkg::alu_req_type req,
   output vsom_pkg::alu_rsp_type rsp
);
   import vsom_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   alu_op_type           op_ff, op_in;
   logic [DW-1:0]        x_ff, x_in;
   logic [DW-1:0]        r_ff, r_in;
   logic [DW-1:0]        b_ff, b_in;
   logic                 ovf_ff, ovf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      op_ff  <= op_in;
      x_ff   <= x_in;
      r_ff   <= r_in;
      b_ff   <= b_in;
      ovf_ff <= ovf_in;
   end

   always_comb begin
      logic [DW:0]   rs;
      logic [DW:0]   dbl;
      logic [DW+1:0] sum;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      b_in    = b_ff;
      ovf_in  = ovf_ff;
      rs      = {r_ff, x_ff[DW-1]};
      dbl     = {x_ff, 1'b0};
      sum     = {1'b0, dbl} + {2'b00, (r_ff[DW-1] ? b_ff : '0)};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         op_in   = req.op;
         ovf_in  = 1'b0;
         if (req.op == ALU_DIV) begin
            x_in = req.a;
            r_in = '0;
            b_in = req.b;
         end else begin
            x_in = '0;
            r_in = req.b;
            b_in = req.a;
         end
      end else if (busy_ff) begin
         if (op_ff == ALU_DIV) begin
            if (rs >= {1'b0, b_ff}) begin
               r_in = DW'(rs - {1'b0, b_ff});
               x_in = {x_ff[DW-2:0], 1'b1};
            end else begin
               r_in = rs[DW-1:0];
               x_in = {x_ff[DW-2:0], 1'b0};
            end
         end else begin
            x_in   = sum[DW-1:0];
            ovf_in = ovf_ff | (sum[DW+1:DW] != 2'b00);
            r_in   = {r_ff[DW-2:0], 1'b0};
         end
         cnt_in = STEP_BITS'(cnt_ff + 1'b1);
         if (cnt_ff == STEP_BITS'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = (op_ff == ALU_MUL && ovf_ff) ? '1 : x_ff;
   assign rsp.rem  = r_ff;

endmodule

// ===== rtl/variable_strip_offset_mapper.sv =====
// Load, unknown commands and queries on an empty table go from idle straight to the done state,
// a zero-size stripe after the size step; others make up to three 64-step passes of the shared
// divide/multiply unit (one bit a cycle) plus table walks of one entry a cycle over the strips.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset clears the control state and both configuration registers; the strip table
// holds no reset value and must be loaded before use.
module variable_strip_offset_mapper #(
   parameter int MAX_STRIPS = vsom_pkg::DEF_MAX_STRIPS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vsom_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vsom_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import vsom_pkg::*;

   localparam int IW = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1;
   localparam int CW = $clog2(MAX_STRIPS + 1);

   logic [4:0]    count_ff;
   logic [7:0]    server_ff;
   state_type     state_ff, state_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [DW-1:0] off_ff, off_in;
   logic [CW-1:0] j_ff, j_in;
   logic [DW-1:0] ssize_ff, ssize_in;
   logic [DW-1:0] tot_ff, tot_in;
   logic [DW-1:0] snr_ff, snr_in;
   logic [DW-1:0] inoff_ff, inoff_in;
   logic [DW-1:0] base_ff, base_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic [DW-1:0] dlt_ff, dlt_in;
   logic [DW-1:0] sel_ff, sel_in;
   logic [DW-1:0] val_ff, val_in;
   logic [1:0]    stat_ff, stat_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic [CW-1:0] n_cnt;
   entry_type     ent;
   entry_type     wr_ent;
   logic          tbl_we;
   alu_req_type   alu_req;
   alu_rsp_type   alu_rsp;

   assign n_cnt = (int'(count_ff) > MAX_STRIPS) ? CW'(MAX_STRIPS) : CW'(count_ff);

   assign wr_ent.start  = req_data.entry_start;
   assign wr_ent.length = req_data.entry_length;
   assign wr_ent.owner  = req_data.entry_owner;
   assign tbl_we = req_valid && req_ready && (req_data.command == CMD_LOAD)
                   && (int'(req_data.entry_index) < MAX_STRIPS);

   vsom_table #(
      .MAX_STRIPS (MAX_STRIPS),
      .IW         (IW)
   ) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (IW'(req_data.entry_index)),
      .wdata (wr_ent),
      .raddr (j_in[IW-1:0]),
      .rdata (ent)
   );

   vsom_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         server_ff <= '0;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == REG_SERVER) begin
            server_ff <= pwdata[7:0];
         end else begin
            count_ff <= pwdata[4:0];
         end
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_SERVER) ? {24'd0, server_ff} : {27'd0, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      off_ff      <= off_in;
      ssize_ff    <= ssize_in;
      tot_ff      <= tot_in;
      snr_ff      <= snr_in;
      inoff_ff    <= inoff_in;
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      dlt_ff      <= dlt_in;
      sel_ff      <= sel_in;
      val_ff      <= val_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      logic          mine;
      logic          at_end;
      logic          inside_strip;
      logic [DW-1:0] ent_s;
      logic [DW-1:0] ent_l;
      logic [DW-1:0] lo;
      logic [DW-1:0] s2;
      logic [DW-1:0] v;
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      off_in       = off_ff;
      j_in         = j_ff;
      ssize_in     = ssize_ff;
      tot_in       = tot_ff;
      snr_in       = snr_ff;
      inoff_in     = inoff_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      dlt_in       = dlt_ff;
      sel_in       = sel_ff;
      val_in       = val_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      alu_req      = '{start: 1'b0, op: ALU_DIV, a: '0, b: '0};
      ent_s        = DW'(ent.start);
      ent_l        = DW'(ent.length);
      mine         = (ent.owner == server_ff[SERVER_BITS-1:0]);
      at_end       = (j_ff == n_cnt);
      inside_strip = (inoff_ff >= ent_s) && ((inoff_ff - ent_s) < ent_l);
      lo           = base_ff + ent_s;
      s2           = sat_add(acc_ff, ent_l);
      v            = sat_add(val_ff, dlt_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_data.command;
               off_in  = DW'(req_data.offset_in);
               val_in  = '0;
               stat_in = ST_OK;
               if (req_data.command == CMD_LOAD || req_data.command > CMD_LEN) begin
                  state_in = S_DONE;
               end else if (n_cnt == '0) begin
                  stat_in  = ST_EMPTY;
                  state_in = S_DONE;
               end else begin
                  j_in     = CW'(n_cnt - 1'b1);
                  state_in = S_SIZE;
               end
            end
         end
         S_SIZE: begin
            ssize_in = ent_s + ent_l;
            if ((ent_s + ent_l) == '0) begin
               stat_in  = ST_EMPTY;
               state_in = S_DONE;
            end else begin
               j_in     = '0;
               tot_in   = '0;
               state_in = S_TOTAL;
            end
         end
         S_TOTAL: begin
            if (!at_end) begin
               if (mine) begin
                  tot_in = sat_add(tot_ff, ent_l);
               end
               j_in = CW'(j_ff + 1'b1);
            end else if (cmd_ff == CMD_L2P || cmd_ff == CMD_NEXT) begin
               alu_req  = '{start: 1'b1, op: ALU_DIV, a: off_ff, b: ssize_ff};
               state_in = S_DIV_A;
            end else if (tot_ff == '0) begin
               stat_in  = ST_EMPTY;
               state_in = S_DONE;
            end else begin
               alu_req  = '{start: 1'b1, op: ALU_DIV, a: off_ff, b: tot_ff};
               state_in = S_DIV_P;
            end
         end
         S_DIV_A: begin
            if (alu_rsp.done) begin
               snr_in   = alu_rsp.quo;
               inoff_in = alu_rsp.rem;
               base_in  = off_ff - alu_rsp.rem;
               j_in     = '0;
               acc_in   = '0;
               state_in = (cmd_ff == CMD_L2P) ? S_L2P : S_C3A;
            end
         end
         S_L2P: begin
            if (at_end) begin
               stat_in  = ST_NOT_OWNED;
               val_in   = '0;
               state_in = S_DONE;
            end else if (mine && off_ff >= lo && (off_ff - lo) < ent_l) begin
               dlt_in   = off_ff - lo;
               alu_req  = '{start: 1'b1, op: ALU_MUL, a: snr_ff, b: tot_ff};
               state_in = S_L2P_MUL;
            end else begin
               if (mine) begin
                  acc_in = s2;
               end
               j_in = CW'(j_ff + 1'b1);
            end
         end
         S_L2P_MUL: begin
            if (alu_rsp.done) begin
               val_in   = sat_add(alu_rsp.quo, acc_ff);
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            val_in = v;
            if (cmd_ff == CMD_LEN) begin
               state_in = S_C4_START;
            end else begin
               stat_in  = ST_OK;
               state_in = S_DONE;
            end
         end
         S_DIV_P: begin
            if (alu_rsp.done) begin
               snr_in   = alu_rsp.quo;
               inoff_in = alu_rsp.rem;
               j_in     = '0;
               acc_in   = '0;
               state_in = S_P2L;
            end
         end
         S_P2L: begin
            if (at_end) begin
               stat_in  = ST_NO_STRIP;
               val_in   = '0;
               state_in = S_DONE;
            end else if (mine && inoff_ff < s2) begin
               dlt_in   = inoff_ff - acc_ff;
               sel_in   = ent_s;
               alu_req  = '{start: 1'b1, op: ALU_MUL, a: snr_ff, b: ssize_ff};
               state_in = S_P2L_MUL;
            end else begin
               if (mine) begin
                  acc_in = s2;
               end
               j_in = CW'(j_ff + 1'b1);
            end
         end
         S_P2L_MUL: begin
            if (alu_rsp.done) begin
               val_in   = sat_add(alu_rsp.quo, sel_ff);
               state_in = S_ADD;
            end
         end
         S_C4_START: begin
            alu_req  = '{start: 1'b1, op: ALU_DIV, a: val_ff, b: ssize_ff};
            state_in = S_C4_DIV;
         end
         S_C4_DIV: begin
            if (alu_rsp.done) begin
               inoff_in = alu_rsp.rem;
               j_in     = '0;
               state_in = S_C4_WALK;
            end
         end
         S_C4_WALK: begin
            if (at_end) begin
               stat_in  = ST_NO_STRIP;
               val_in   = '0;
               state_in = S_DONE;
            end else if (inside_strip) begin
               val_in   = ent_s + ent_l - inoff_ff;
               stat_in  = ST_OK;
               state_in = S_DONE;
            end else begin
               j_in = CW'(j_ff + 1'b1);
            end
         end
         S_C3A: begin
            if (at_end) begin
               alu_req  = '{start: 1'b1, op: ALU_MUL, a: sat_add(snr_ff, DW'(1)), b: ssize_ff};
               state_in = S_C3_MUL;
            end else if (inside_strip && mine) begin
               val_in   = off_ff;
               stat_in  = ST_OK;
               state_in = S_DONE;
            end else begin
               j_in = CW'(j_ff + 1'b1);
               if (inside_strip) begin
                  state_in = S_C3B;
               end
            end
         end
         S_C3B: begin
            if (at_end) begin
               alu_req  = '{start: 1'b1, op: ALU_MUL, a: sat_add(snr_ff, DW'(1)), b: ssize_ff};
               state_in = S_C3_MUL;
            end else if (mine) begin
               val_in   = sat_add(base_ff, ent_s);
               stat_in  = ST_OK;
               state_in = S_DONE;
            end else begin
               j_in = CW'(j_ff + 1'b1);
            end
         end
         S_C3_MUL: begin
            if (alu_rsp.done) begin
               base_in  = alu_rsp.quo;
               j_in     = '0;
               state_in = S_C3C;
            end
         end
         S_C3C: begin
            if (at_end) begin
               stat_in  = ST_NOT_OWNED;
               val_in   = '0;
               state_in = S_DONE;
            end else if (mine) begin
               val_in   = sat_add(base_ff, ent_s);
               stat_in  = ST_OK;
               state_in = S_DONE;
            end else begin
               j_in = CW'(j_ff + 1'b1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = stat_ff;
               rsp_data_in.result_value = (val_ff > OFF_MAX) ? '1
                                          : val_ff[OFFSET_BITS-1:0];
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/vsom_checker.sv =====
module vsom_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input vsom_pkg::rsp_type rsp_data
);
   import vsom_pkg::*;

   busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("block ready in the cycle after taking an item");

   error_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.result_value == '0)
      else $error("error status with a non-zero value");

   stalled_item_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed or dropped");

   no_result_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result item shown straight after reset");

endmodule

bind variable_strip_offset_mapper vsom_checker u_vsom_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
